@@ src/audio_noise_gate_macros.svh @@
// ----------------------------------------------------------------------------
// audio_noise_gate_macros.svh
// Assertion macros shared by the noise gate RTL.
// ----------------------------------------------------------------------------
`ifndef AUDIO_NOISE_GATE_MACROS_SVH
`define AUDIO_NOISE_GATE_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define ANG_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define ANG_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ src/ang_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// ang_pkg
// Types and constants shared by the noise gate modules.
// ----------------------------------------------------------------------------
package ang_pkg;

   localparam int unsigned CSR_INDEX_WIDTH = 3;
   localparam int unsigned CSR_DATA_WIDTH  = 32;
   localparam int unsigned LEVEL_WIDTH     = 16;
   localparam int unsigned HOLD_REG_WIDTH  = 20;

   // Q1.15 unity
   localparam logic [LEVEL_WIDTH-1:0] UNITY = 16'h8000;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_BYPASS    = 3'd0,
      CSR_THRESHOLD = 3'd1,
      CSR_ATTACK    = 3'd2,
      CSR_DECAY     = 3'd3,
      CSR_HOLD      = 3'd4,
      CSR_RANGE     = 3'd5
   } csr_index_type;

   typedef enum logic [1:0] {
      PHASE_CLOSED = 2'd0,
      PHASE_ATTACK = 2'd1,
      PHASE_OPENED = 2'd2,
      PHASE_DECAY  = 2'd3
   } gate_phase_type;

   typedef enum logic {
      SEQ_IDLE  = 1'b0,
      SEQ_SCALE = 1'b1
   } seq_state_type;

   typedef struct packed {
      logic                   bypass;
      logic [LEVEL_WIDTH-1:0] threshold_level;
      logic [LEVEL_WIDTH-1:0] attack_step;
      logic [LEVEL_WIDTH-1:0] decay_step;
      logic [LEVEL_WIDTH-1:0] range_gain;
   } ang_cfg_type;

   typedef struct packed {
      gate_phase_type         phase;
      logic [LEVEL_WIDTH-1:0] level;
   } ang_gate_out_type;

endpackage
`default_nettype wire

@@ src/ang_csr.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// ang_csr
// Configuration register file; writes are always taken.
// ----------------------------------------------------------------------------
module ang_csr #(
   parameter int unsigned HOLD_WIDTH = 20
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 csr_valid,
   output      logic                                 csr_ready,
   input  wire logic [ang_pkg::CSR_INDEX_WIDTH-1:0]  csr_index,
   input  wire logic [ang_pkg::CSR_DATA_WIDTH-1:0]   csr_wdata,
   output      ang_pkg::ang_cfg_type                 cfg,
   output      logic [HOLD_WIDTH-1:0]                hold_samples
);
   import ang_pkg::*;

   ang_cfg_type           cfg_ff, cfg_in;
   logic [HOLD_WIDTH-1:0] hold_ff, hold_in;

   assign csr_ready    = 1'b1;
   assign cfg          = cfg_ff;
   assign hold_samples = hold_ff;

   always_comb begin
      cfg_in  = cfg_ff;
      hold_in = hold_ff;
      if (csr_valid) begin
         case (csr_index_type'(csr_index))
            CSR_BYPASS:    cfg_in.bypass          = csr_wdata[0];
            CSR_THRESHOLD: cfg_in.threshold_level = csr_wdata[LEVEL_WIDTH-1:0];
            CSR_ATTACK:    cfg_in.attack_step     = csr_wdata[LEVEL_WIDTH-1:0];
            CSR_DECAY:     cfg_in.decay_step      = csr_wdata[LEVEL_WIDTH-1:0];
            CSR_HOLD:      hold_in = HOLD_WIDTH'(csr_wdata[HOLD_REG_WIDTH-1:0]);
            CSR_RANGE:     cfg_in.range_gain      = csr_wdata[LEVEL_WIDTH-1:0];
            default:       cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.bypass          <= 1'b0;
         cfg_ff.threshold_level <= 16'd328;
         cfg_ff.attack_step     <= 16'd68;
         cfg_ff.decay_step      <= 16'd7;
         cfg_ff.range_gain      <= 16'd0;
         hold_ff                <= HOLD_WIDTH'(20'd4800);
      end else begin
         cfg_ff  <= cfg_in;
         hold_ff <= hold_in;
      end
   end

endmodule
`default_nettype wire

@@ src/ang_gate.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// ang_gate
// Gate phase, gate level and hold counter with their per-word update.
// ----------------------------------------------------------------------------
module ang_gate #(
   parameter int unsigned SAMPLE_WIDTH = 16,
   parameter int unsigned HOLD_WIDTH   = 20
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             advance,
   input  wire logic signed [SAMPLE_WIDTH-1:0]   sample,
   input  wire ang_pkg::ang_cfg_type             cfg,
   input  wire logic [HOLD_WIDTH-1:0]            hold_samples,
   output      ang_pkg::ang_gate_out_type        step
);
   import ang_pkg::*;

   localparam int unsigned CW = (SAMPLE_WIDTH > LEVEL_WIDTH) ? SAMPLE_WIDTH : LEVEL_WIDTH;

   gate_phase_type         phase_ff, phase_in;
   logic [LEVEL_WIDTH-1:0] level_ff, level_in;
   logic [HOLD_WIDTH-1:0]  hold_ff, hold_in;
   logic [SAMPLE_WIDTH-1:0] sample_u, mag;
   logic                   loud;
   gate_phase_type         phase_mid;
   logic [LEVEL_WIDTH:0]   attack_sum;

   // magnitude of the most negative sample comes out as 2^(W-1), unsigned
   assign sample_u   = sample;
   assign mag        = sample_u[SAMPLE_WIDTH-1] ? (~sample_u + 1'b1) : sample_u;
   assign loud       = CW'(mag) >= CW'(cfg.threshold_level);
   assign attack_sum = {1'b0, level_ff} + {1'b0, cfg.attack_step};

   always_comb begin
      phase_mid = phase_ff;
      hold_in   = hold_ff;
      level_in  = level_ff;
      // first pass: react to the sample level
      case (phase_ff)
         PHASE_CLOSED, PHASE_DECAY: begin
            if (loud) phase_mid = PHASE_ATTACK;
         end
         PHASE_OPENED: begin
            if (loud) hold_in = hold_samples;
            else if (hold_ff == '0) phase_mid = PHASE_DECAY;
            else hold_in = hold_ff - 1'b1;
         end
         default: phase_mid = phase_ff;
      endcase
      phase_in = phase_mid;
      // second pass: ramp the level
      case (phase_mid)
         PHASE_DECAY: begin
            if (level_ff <= cfg.decay_step) begin
               level_in = '0;
               phase_in = PHASE_CLOSED;
            end else begin
               level_in = level_ff - cfg.decay_step;
            end
         end
         PHASE_ATTACK: begin
            if (attack_sum >= {1'b0, UNITY}) begin
               level_in = UNITY;
               phase_in = PHASE_OPENED;
               hold_in  = hold_samples;
            end else begin
               level_in = attack_sum[LEVEL_WIDTH-1:0];
            end
         end
         default: level_in = level_ff;
      endcase
   end

   // bypass shows the frozen state
   assign step.phase = cfg.bypass ? phase_ff : phase_in;
   assign step.level = cfg.bypass ? level_ff : level_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PHASE_CLOSED;
         level_ff <= '0;
         hold_ff  <= '0;
      end else if (advance) begin
         phase_ff <= phase_in;
         level_ff <= level_in;
         hold_ff  <= hold_in;
      end
   end

endmodule
`default_nettype wire

@@ src/ang_mul.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// ang_mul
// Shared signed-by-unsigned multiplier for gain mix and sample scaling.
// ----------------------------------------------------------------------------
module ang_mul #(
   parameter int unsigned A_WIDTH = 17
) (
   input  wire logic signed [A_WIDTH-1:0]                  op_a,
   input  wire logic [ang_pkg::LEVEL_WIDTH-1:0]            op_b,
   output      logic signed [A_WIDTH+ang_pkg::LEVEL_WIDTH:0] product
);
   import ang_pkg::*;

   logic signed [LEVEL_WIDTH:0] op_b_s;

   assign op_b_s  = $signed({1'b0, op_b});
   assign product = op_a * op_b_s;

endmodule
`default_nettype wire

@@ src/audio_noise_gate.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// audio_noise_gate
// Noise gate with attack, hold and decay phases over signed Q1.15 samples.
// ----------------------------------------------------------------------------
//
//   channel | ports                                  | direction
//   --------+----------------------------------------+----------
//   req     | req_valid, req_stall, req_sample_in    | in
//   rsp     | rsp_valid, rsp_stall, rsp_sample_out,  | out
//           | rsp_gate_phase                         |
//   csr     | csr_valid, csr_ready, csr_index,       | in
//           | csr_wdata                              |
//
// Each word takes an idle step and a scale step; one multiplier is shared between the
// gain mix (gate * (1 - range)) and the sample scaling (sample * gain).
// The idle step accepts the word, steps the gate state and forms the gain;
// the scale step scales the sample into the output register.
// A stalled output holds the sequencer in its scale step; a new word is
// still taken while a finished word waits in the output register.
// Reset is synchronous and returns control and CSR registers to defaults, gate closed.
// ----------------------------------------------------------------------------
`include "audio_noise_gate_macros.svh"

module audio_noise_gate #(
   parameter int unsigned SAMPLE_WIDTH = 16,
   parameter int unsigned HOLD_WIDTH   = 20
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   // input samples
   input  wire logic                                 req_valid,
   output      logic                                 req_stall,
   input  wire logic signed [SAMPLE_WIDTH-1:0]       req_sample_in,
   // gated samples
   output      logic                                 rsp_valid,
   input  wire logic                                 rsp_stall,
   output      logic signed [SAMPLE_WIDTH-1:0]       rsp_sample_out,
   output      logic [1:0]                           rsp_gate_phase,
   // configuration
   input  wire logic                                 csr_valid,
   output      logic                                 csr_ready,
   input  wire logic [ang_pkg::CSR_INDEX_WIDTH-1:0]  csr_index,
   input  wire logic [ang_pkg::CSR_DATA_WIDTH-1:0]   csr_wdata
);
   import ang_pkg::*;

   // multiplier operand and product widths
   localparam int unsigned AW = ((SAMPLE_WIDTH > LEVEL_WIDTH) ? SAMPLE_WIDTH : LEVEL_WIDTH) + 1;
   localparam int unsigned PW = AW + LEVEL_WIDTH + 1;

   ang_cfg_type               cfg;
   logic [HOLD_WIDTH-1:0]     hold_samples;
   ang_gate_out_type          step;

   seq_state_type             state_ff, state_in;
   logic signed [SAMPLE_WIDTH-1:0] sample_ff;
   logic [LEVEL_WIDTH-1:0]    gain_ff, gain_in;
   gate_phase_type            phase_ff;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic signed [SAMPLE_WIDTH-1:0] rsp_sample_ff, rsp_sample_in;
   logic [1:0]                rsp_phase_ff;

   logic                      accept;
   logic                      out_load;
   logic                      scale_sel;
   logic [LEVEL_WIDTH-1:0]    range;
   logic signed [AW-1:0]      op_a;
   logic [LEVEL_WIDTH-1:0]    op_b;
   logic signed [PW-1:0]      product;
   logic signed [PW-1:0]      scaled;
   logic                      fits;

   // --- configuration registers ---
   ang_csr #(
      .HOLD_WIDTH (HOLD_WIDTH)
   ) u_csr (
      .clock        (clock),
      .reset        (reset),
      .csr_valid    (csr_valid),
      .csr_ready    (csr_ready),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .cfg          (cfg),
      .hold_samples (hold_samples)
   );

   // --- gate state: advance on every accepted word unless bypassed ---
   ang_gate #(
      .SAMPLE_WIDTH (SAMPLE_WIDTH),
      .HOLD_WIDTH   (HOLD_WIDTH)
   ) u_gate (
      .clock        (clock),
      .reset        (reset),
      .advance      (accept && !cfg.bypass),
      .sample       (req_sample_in),
      .cfg          (cfg),
      .hold_samples (hold_samples),
      .step         (step)
   );

   // --- sequencer: next state ---
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         SEQ_IDLE:  if (accept) state_in = SEQ_SCALE;
         SEQ_SCALE: if (out_load) state_in = SEQ_IDLE;
         default:   state_in = SEQ_IDLE;
      endcase
   end

   // --- sequencer: outputs ---
   always_comb begin
      req_stall = 1'b1;
      scale_sel = 1'b0;
      out_load  = 1'b0;
      case (state_ff)
         SEQ_IDLE: begin
            req_stall = 1'b0;
         end
         SEQ_SCALE: begin
            scale_sel = 1'b1;
            // load the output register once it is empty or being drained
            out_load  = !rsp_valid_ff || !rsp_stall;
         end
         default: req_stall = 1'b1;
      endcase
   end

   assign accept = req_valid && !req_stall;

   // range above unity clamps to unity
   assign range = (cfg.range_gain > UNITY) ? UNITY : cfg.range_gain;

   // --- shared multiplier: gate mix in the accept cycle, scaling after ---
   assign op_a = scale_sel ? AW'(sample_ff) : $signed(AW'(step.level));
   assign op_b = scale_sel ? gain_ff : (UNITY - range);

   ang_mul #(
      .A_WIDTH (AW)
   ) u_mul (
      .op_a    (op_a),
      .op_b    (op_b),
      .product (product)
   );

   // gain = range + gate * (1 - range); bypass passes the sample at unity
   assign gain_in = cfg.bypass ? UNITY
                  : range + product[2*LEVEL_WIDTH-2:LEVEL_WIDTH-1];

   // floor shift, then saturate to the sample width
   assign scaled = product >>> (LEVEL_WIDTH - 1);
   assign fits   = (scaled[PW-1:SAMPLE_WIDTH-1] == '0) || (scaled[PW-1:SAMPLE_WIDTH-1] == '1);

   always_comb begin
      if (fits) begin
         rsp_sample_in = scaled[SAMPLE_WIDTH-1:0];
      end else if (scaled[PW-1]) begin
         rsp_sample_in = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};
      end else begin
         rsp_sample_in = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (out_load) rsp_valid_in = 1'b1;
      else if (rsp_valid_ff && !rsp_stall) rsp_valid_in = 1'b0;
   end

   // --- control registers ---
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= SEQ_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // --- payload registers: hold the word between the idle and scale steps ---
   always_ff @(posedge clock) begin
      if (accept) begin
         sample_ff <= req_sample_in;
         gain_ff   <= gain_in;
         phase_ff  <= step.phase;
      end
      if (out_load) begin
         rsp_sample_ff <= rsp_sample_in;
         rsp_phase_ff  <= phase_ff;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_sample_out = rsp_sample_ff;
   assign rsp_gate_phase = rsp_phase_ff;

   // --- assertions ---
   `ANG_ASSERT_NEXT(a_accept_scales, clock, reset, accept, state_ff == SEQ_SCALE, "accepted word did not enter the scale step")
   `ANG_ASSERT_NEXT(a_gain_unity, clock, reset, accept, gain_ff <= UNITY, "gain above unity")
   `ANG_ASSERT_NOW(a_level_unity, clock, reset, 1'b1, step.level <= UNITY, "gate level above unity")
   `ANG_ASSERT_NEXT(a_bypass_pass, clock, reset, out_load && cfg.bypass, rsp_sample_out == $past(sample_ff), "bypass changed the sample")

endmodule
`default_nettype wire

@@ tb/audio_noise_gate_tb.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// audio_noise_gate_tb
// Self-checking bench for the attack/hold/decay noise gate.
// A directed table covers reset defaults, full-scale samples, half and
// over-unity range, threshold extremes, zero steps, bypass and unused
// register indexes. Random phases follow, each with its own register
// setting, driving loud bursts and quiet runs so that the gate cycles
// through all four phases. Every output word is compared with a
// bit-accurate gate predictor kept inside the bench.
// ----------------------------------------------------------------------------
module audio_noise_gate_tb;
   import ang_pkg::*;

   localparam int SAMPLE_W     = 16;
   localparam int HOLD_W       = 20;
   localparam int RESET_CYCLES = 12;
   localparam int NUM_PHASES   = 12;
   localparam int PHASE_WORDS  = 53;
   localparam int DRAIN_CYCLES = 8;
   localparam int LIMIT_CYCLES = 200000;
   localparam int MAX_PRINTS   = 60;
   localparam int unsigned FULL_GAIN = UNITY;

   // Indexes past the register list; writes there must be dropped.
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_SPARE_A = 3'd6;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_SPARE_B = 3'd7;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] sample;
      gate_phase_type             phase;
   } gated_word_t;

   typedef enum logic {
      ROW_WORD = 1'b0,
      ROW_CSR  = 1'b1
   } row_kind_t;

   typedef struct {
      row_kind_t                  kind;
      logic [CSR_INDEX_WIDTH-1:0] idx;
      logic [CSR_DATA_WIDTH-1:0]  data;
      logic signed [SAMPLE_W-1:0] sample;
      logic                       typed;
      gated_word_t                fixed;
   } gate_row_t;

   // ---------------------------------------------------------------------
   // Signals
   // ---------------------------------------------------------------------
   logic                             clock = 1'b0;
   logic                             reset = 1'b1;
   logic                             req_valid = 1'b0;
   logic                             req_stall;
   logic signed [SAMPLE_W-1:0]       req_sample_in = '0;
   logic                             rsp_valid;
   logic                             rsp_stall = 1'b0;
   logic signed [SAMPLE_W-1:0]       rsp_sample_out;
   logic [1:0]                       rsp_gate_phase;
   logic                             csr_valid = 1'b0;
   logic                             csr_ready;
   logic [CSR_INDEX_WIDTH-1:0]       csr_index = '0;
   logic [CSR_DATA_WIDTH-1:0]        csr_wdata = '0;

   // Stretches with no idling on either side.
   logic                             steady = 1'b0;

   int                               error_count = 0;
   int                               checked_words = 0;
   int                               stall_left = 0;

   gated_word_t                      pending_words[$];

   // Register copy, reset values.
   logic                             cfg_bypass    = 1'b0;
   logic [15:0]                      cfg_threshold = 16'd328;
   logic [15:0]                      cfg_attack    = 16'd68;
   logic [15:0]                      cfg_decay     = 16'd7;
   logic [HOLD_W-1:0]                cfg_hold      = 20'd4800;
   logic [15:0]                      cfg_range     = 16'd0;

   // Gate state copy, reset values.
   gate_phase_type                   gate_ph   = PHASE_CLOSED;
   int unsigned                      gate_lvl  = 0;
   logic [HOLD_W-1:0]                hold_cnt  = '0;

   // ---------------------------------------------------------------------
   // Block under test
   // ---------------------------------------------------------------------
   audio_noise_gate #(
      .SAMPLE_WIDTH (SAMPLE_W),
      .HOLD_WIDTH   (HOLD_W)
   ) uut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_sample_in  (req_sample_in),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_sample_out (rsp_sample_out),
      .rsp_gate_phase (rsp_gate_phase),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Hard stop in case a handshake never completes.
   initial begin
      #(LIMIT_CYCLES * 20);
      $display("RESULT: ERROR");
      $finish;
   end

   // ---------------------------------------------------------------------
   // Gate predictor
   // ---------------------------------------------------------------------

   // floor(s * gain / 2^15), clamped to the sample range
   function automatic logic signed [SAMPLE_W-1:0] scale_by(
      input logic signed [SAMPLE_W-1:0] s,
      input int unsigned                gain
   );
      longint prod;
      longint res;
      prod = longint'(s) * longint'(gain);
      res  = prod >>> 15;
      if (res > 32767)  res = 32767;
      if (res < -32768) res = -32768;
      return res[SAMPLE_W-1:0];
   endfunction

   // range + gate * (1 - range), all Q1.15
   function automatic int unsigned mix_gain(input int unsigned range_q);
      longint unsigned part;
      part = (longint'(gate_lvl) * longint'(FULL_GAIN - range_q)) >> 15;
      return range_q + int'(part);
   endfunction

   task automatic gate_predict(
      input  logic signed [SAMPLE_W-1:0] s,
      output gated_word_t                w
   );
      int unsigned                mag;
      logic                       loud;
      int unsigned                range_q;
      logic signed [SAMPLE_W-1:0] y;
      mag     = (s < 0) ? -int'(s) : int'(s);
      loud    = (mag >= cfg_threshold);
      range_q = (cfg_range > UNITY) ? FULL_GAIN : cfg_range;
      y       = s;
      if (!cfg_bypass) begin
         // Phase transitions driven by the sample level.
         case (gate_ph)
            PHASE_CLOSED, PHASE_DECAY: begin
               if (loud) gate_ph = PHASE_ATTACK;
            end
            PHASE_OPENED: begin
               if (loud) hold_cnt = cfg_hold;
               else if (hold_cnt == 0) gate_ph = PHASE_DECAY;
               else hold_cnt = hold_cnt - 1'b1;
            end
            default: ;
         endcase
         // Ramp the gate level and scale the sample.
         case (gate_ph)
            PHASE_CLOSED: begin
               y = scale_by(s, range_q);
            end
            PHASE_DECAY: begin
               if (gate_lvl <= cfg_decay) begin
                  gate_lvl = 0;
                  gate_ph  = PHASE_CLOSED;
               end else begin
                  gate_lvl = gate_lvl - cfg_decay;
               end
               y = scale_by(s, mix_gain(range_q));
            end
            PHASE_ATTACK: begin
               gate_lvl = gate_lvl + cfg_attack;
               if (gate_lvl >= FULL_GAIN) begin
                  gate_lvl = FULL_GAIN;
                  gate_ph  = PHASE_OPENED;
                  hold_cnt = cfg_hold;
               end
               y = scale_by(s, mix_gain(range_q));
            end
            default: y = s;
         endcase
      end
      w.sample = y;
      w.phase  = gate_ph;
   endtask

   // ---------------------------------------------------------------------
   // Stimulus helpers
   // ---------------------------------------------------------------------
   function automatic int draw_wait();
      return steady ? 0 : int'($urandom_range(3, 0));
   endfunction

   // Fill the bits above a register's width with noise; the block must mask them.
   function automatic logic [CSR_DATA_WIDTH-1:0] with_junk_bits(
      input logic [CSR_DATA_WIDTH-1:0] value,
      input int                        width
   );
      logic [CSR_DATA_WIDTH-1:0] keep;
      keep = (32'h1 << width) - 1;
      return ($urandom() & ~keep) | (value & keep);
   endfunction

   // Loud or quiet sample relative to the current threshold.
   function automatic logic signed [SAMPLE_W-1:0] make_sample(input logic loud);
      int unsigned                lo;
      int unsigned                hi;
      int unsigned                m;
      logic signed [SAMPLE_W-1:0] s;
      if (loud && cfg_threshold <= UNITY) begin
         lo = cfg_threshold;
         hi = FULL_GAIN;
      end else if (!loud && cfg_threshold != 0) begin
         lo = 0;
         hi = (cfg_threshold > UNITY) ? FULL_GAIN : cfg_threshold - 1;
      end else begin
         return $urandom();
      end
      m = $urandom_range(hi, lo);
      if (m == FULL_GAIN) return 16'sh8000;
      s = m[SAMPLE_W-1:0];
      return ($urandom_range(1, 0) != 0) ? -s : s;
   endfunction

   task automatic report_mismatch(input string what);
      error_count++;
      if (error_count <= MAX_PRINTS) $display("MISMATCH @%0t: %s", $time, what);
   endtask

   // Drop valid and hold until every expected word has come back.
   task automatic wait_drained();
      req_valid <= 1'b0;
      while (pending_words.size() != 0) @(posedge clock);
   endtask

   task automatic csr_write(
      input logic [CSR_INDEX_WIDTH-1:0] idx,
      input logic [CSR_DATA_WIDTH-1:0]  data
   );
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      case (idx)
         CSR_BYPASS:    cfg_bypass    = data[0];
         CSR_THRESHOLD: cfg_threshold = data[15:0];
         CSR_ATTACK:    cfg_attack    = data[15:0];
         CSR_DECAY:     cfg_decay     = data[15:0];
         CSR_HOLD:      cfg_hold      = data[HOLD_W-1:0];
         CSR_RANGE:     cfg_range     = data[15:0];
         default: ;
      endcase
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   // Present one sample word, keep it stable until taken, then log its result.
   task automatic send_sample(
      input logic signed [SAMPLE_W-1:0] s,
      input int                         gap,
      input logic                       typed,
      input gated_word_t                fixed
   );
      gated_word_t w;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_sample_in <= s;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      gate_predict(s, w);
      pending_words.push_back(typed ? fixed : w);
   endtask

   // ---------------------------------------------------------------------
   // Result side: stall at random, check every accepted word
   // ---------------------------------------------------------------------
   always @(posedge clock) begin : rsp_side
      gated_word_t want;
      int          n;
      if (reset) begin
         rsp_stall  <= 1'b0;
         stall_left <= 0;
      end else if (rsp_valid && !rsp_stall) begin
         if (pending_words.size() == 0) begin
            report_mismatch($sformatf("unexpected word, sample_out %0d", rsp_sample_out));
         end else begin
            want = pending_words.pop_front();
            if (rsp_sample_out !== want.sample)
               report_mismatch($sformatf("word %0d: sample_out %0d, expected %0d",
                  checked_words, rsp_sample_out, want.sample));
            if (rsp_gate_phase !== want.phase)
               report_mismatch($sformatf("word %0d: gate_phase %0d, expected %0d",
                  checked_words, rsp_gate_phase, want.phase));
         end
         checked_words++;
         // Draw the back-pressure that follows this word.
         n = draw_wait();
         if (n > 0) begin
            rsp_stall  <= 1'b1;
            stall_left <= n;
         end
      end else if (rsp_stall) begin
         if (stall_left <= 1) rsp_stall <= 1'b0;
         stall_left <= stall_left - 1;
      end
   end

   // ---------------------------------------------------------------------
   // Directed table: typed expectations where they are obvious
   // ---------------------------------------------------------------------
   localparam int DIRECTED_ROWS = 38;

   gate_row_t directed_rows [DIRECTED_ROWS] = '{
      // reset defaults: threshold 328, range zero
      '{ROW_WORD, CSR_BYPASS,    32'h0,         16'sd0,      1'b1, '{16'sd0,      PHASE_CLOSED}},
      '{ROW_WORD, CSR_BYPASS,    32'h0,         16'sd327,    1'b1, '{16'sd0,      PHASE_CLOSED}},
      '{ROW_WORD, CSR_BYPASS,    32'h0,         16'sh8000,   1'b1, '{-16'sd68,    PHASE_ATTACK}},
      '{ROW_WORD, CSR_BYPASS,    32'h0,         16'sd32767,  1'b0, '{16'sd0,      PHASE_CLOSED}},
      // short hold, full-step attack; junk in the upper bits
      '{ROW_CSR,  CSR_HOLD,      32'hFFF0_0001, 16'sd0,      1'b0, '{16'sd0,      PHASE_CLOSED}},
      '{ROW_CSR,  CSR_ATTACK,    32'hFFFF_8000, 16'sd0,      1'b0, '{16'sd0,      PHASE_CLOSED}},
      '{ROW_WORD, CSR_BYPASS,    32'h0,         16'sd328,    1'b1, '{16'sd328,    PHASE_OPENED}},
      '{ROW_WORD, CSR_BYPASS,    32'h0,         16'sd100,    1'b1, '{16'sd100,    PHASE_OPENED}},
      '{ROW_WORD, CSR_BYPASS,    32'h0,         -16'sd5,     1'b0, '{16'sd0,      PHASE_CLOSED}},
      '{ROW_CSR,  CSR_DECAY,     32'h0001_8000, 16'sd0,      1'b0, '{16'sd0,      PHASE_CLOSED}},
      '{ROW_WORD, CSR_BYPASS,    32'h0,         -16'sd300,   1'b1, '{16'sd0,      PHASE_CLOSED}},
      // range above unity acts as unity
      '{ROW_CSR,  CSR_RANGE,     32'h0000_FFFF, 16'sd0,      1'b0, '{16'sd0,      PHASE_CLOSED}},
      '{ROW_WORD, CSR_BYPASS,    32'h0,         -16'sd300,   1'b1, '{-16'sd300,   PHASE_CLOSED}},
      // half range: negative products round toward minus infinity
      '{ROW_CSR,  CSR_RANGE,     32'h0000_4000, 16'sd0,      1'b0, '{16'sd0,      PHASE_CLOSED}},
      '{ROW_WORD, CSR_BYPASS,    32'h0,         -16'sd3,     1'b1, '{-16'sd2,     PHASE_CLOSED}},
      '{ROW_WORD, CSR_BYPASS,    32'h0,         16'sd3,      1'b1, '{16'sd1,      PHASE_CLOSED}},
      // threshold above full scale never opens
      '{ROW_CSR,  CSR_THRESHOLD, 32'h0000_FFFF, 16'sd0,      1'b0, '{16'sd0,      PHASE_CLOSED}},
      '{ROW_WORD, CSR_BYPASS,    32'h0,         16'sh8000,   1'b1, '{-16'sd16384, PHASE_CLOSED}},
      '{ROW_WORD, CSR_BYPASS,    32'h0,         16'sd32767,  1'b1, '{16'sd16383,  PHASE_CLOSED}},
      // threshold at unity: only the most negative sample is loud
      '{ROW_CSR,  CSR_THRESHOLD, 32'h0000_8000, 16'sd0,      1'b0, '{16'sd0,      PHASE_CLOSED}},
      '{ROW_WORD, CSR_BYPASS,    32'h0,         16'sd32767,  1'b0, '{16'sd0,      PHASE_CLOSED}},
      '{ROW_WORD, CSR_BYPASS,    32'h0,         16'sh8000,   1'b1, '{16'sh8000,   PHASE_OPENED}},
      // zero decay step: level stays, phase stays in decay
      '{ROW_CSR,  CSR_DECAY,     32'h0000_0000, 16'sd0,      1'b0, '{16'sd0,      PHASE_CLOSED}},
      '{ROW_WORD, CSR_BYPASS,    32'h0,         16'sd5,      1'b0, '{16'sd0,      PHASE_CLOSED}},
      '{ROW_WORD, CSR_BYPASS,    32'h0,         16'sd5,      1'b0, '{16'sd0,      PHASE_CLOSED}},
      '{ROW_WORD, CSR_BYPASS,    32'h0,         16'sd6,      1'b0, '{16'sd0,      PHASE_CLOSED}},
      '{ROW_CSR,  CSR_DECAY,     32'h0000_4000, 16'sd0,      1'b0, '{16'sd0,      PHASE_CLOSED}},
      '{ROW_WORD, CSR_BYPASS,    32'h0,         16'sd7,      1'b0, '{16'sd0,      PHASE_CLOSED}},
      // zero attack step: stuck in attack below unity
      '{ROW_CSR,  CSR_ATTACK,    32'h0000_0000, 16'sd0,      1'b0, '{16'sd0,      PHASE_CLOSED}},
      '{ROW_WORD, CSR_BYPASS,    32'h0,         16'sh8000,   1'b0, '{16'sd0,      PHASE_CLOSED}},
      '{ROW_WORD, CSR_BYPASS,    32'h0,         16'sd0,      1'b0, '{16'sd0,      PHASE_CLOSED}},
      // bypass: sample passes, phase frozen
      '{ROW_CSR,  CSR_BYPASS,    32'hFFFF_FFFF, 16'sd0,      1'b0, '{16'sd0,      PHASE_CLOSED}},
      '{ROW_WORD, CSR_BYPASS,    32'h0,         16'sd1234,   1'b1, '{16'sd1234,   PHASE_ATTACK}},
      '{ROW_WORD, CSR_BYPASS,    32'h0,         16'sh8000,   1'b1, '{16'sh8000,   PHASE_ATTACK}},
      '{ROW_CSR,  CSR_BYPASS,    32'h0000_0000, 16'sd0,      1'b0, '{16'sd0,      PHASE_CLOSED}},
      // unused indexes: drop the write
      '{ROW_CSR,  CSR_SPARE_A,   32'hFFFF_FFFF, 16'sd0,      1'b0, '{16'sd0,      PHASE_CLOSED}},
      '{ROW_CSR,  CSR_SPARE_B,   32'h0000_0000, 16'sd0,      1'b0, '{16'sd0,      PHASE_CLOSED}},
      '{ROW_WORD, CSR_BYPASS,    32'h0,         16'sd0,      1'b0, '{16'sd0,      PHASE_CLOSED}}
   };

   // ---------------------------------------------------------------------
   // Main sequence
   // ---------------------------------------------------------------------
   initial begin
      gated_word_t       unused_word;
      int                sent;
      int                run;
      logic              byp_v;
      logic [15:0]       thr_v;
      logic [15:0]       atk_v;
      logic [15:0]       dec_v;
      logic [15:0]       rng_v;
      logic [HOLD_W-1:0] hold_v;

      unused_word = '{16'sd0, PHASE_CLOSED};

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part: registers change only once the gate is drained.
      foreach (directed_rows[i]) begin
         if (directed_rows[i].kind == ROW_CSR) begin
            wait_drained();
            csr_write(directed_rows[i].idx, directed_rows[i].data);
         end else begin
            send_sample(directed_rows[i].sample, draw_wait(),
               directed_rows[i].typed, directed_rows[i].fixed);
         end
      end

      // Random part: one register setting per phase.
      for (int ph = 0; ph < NUM_PHASES; ph++) begin
         wait_drained();
         if (ph == 0) begin
            // lower extremes
            byp_v = 1'b0; thr_v = 16'd0; atk_v = 16'd1; dec_v = 16'd1;
            hold_v = '0; rng_v = 16'd0;
         end else if (ph == 1) begin
            // upper extremes
            byp_v = 1'b0; thr_v = UNITY; atk_v = UNITY; dec_v = UNITY;
            hold_v = '1; rng_v = UNITY;
         end else begin
            byp_v = ($urandom_range(7, 0) == 0);
            thr_v = ($urandom_range(7, 0) == 0) ? $urandom() : $urandom_range(12000, 50);
            atk_v = ($urandom_range(7, 0) == 0) ? $urandom() : $urandom_range(32768, 2000);
            dec_v = ($urandom_range(7, 0) == 0) ? $urandom() : $urandom_range(32768, 2000);
            hold_v = ($urandom_range(7, 0) == 0) ? $urandom() : $urandom_range(6, 0);
            rng_v = ($urandom_range(7, 0) == 0) ? $urandom() : $urandom_range(32768, 0);
         end
         csr_write(CSR_BYPASS,    with_junk_bits(byp_v, 1));
         csr_write(CSR_THRESHOLD, with_junk_bits(thr_v, 16));
         csr_write(CSR_ATTACK,    with_junk_bits(atk_v, 16));
         csr_write(CSR_DECAY,     with_junk_bits(dec_v, 16));
         csr_write(CSR_HOLD,      with_junk_bits(hold_v, HOLD_W));
         csr_write(CSR_RANGE,     with_junk_bits(rng_v, 16));
         if ($urandom_range(3, 0) == 0) csr_write(CSR_SPARE_A, $urandom());
         steady <= (ph % 4 == 2);

         // Loud bursts followed by quiet runs, with some full-range noise.
         sent = 0;
         while (sent < PHASE_WORDS) begin
            if ($urandom_range(9, 0) == 0) begin
               send_sample($urandom(), draw_wait(), 1'b0, unused_word);
               sent++;
            end else begin
               run = $urandom_range(6, 1);
               for (int k = 0; k < run; k++) begin
                  send_sample(make_sample(1'b1), draw_wait(), 1'b0, unused_word);
                  sent++;
               end
               run = $urandom_range(16, 1);
               for (int k = 0; k < run; k++) begin
                  send_sample(make_sample(1'b0), draw_wait(), 1'b0, unused_word);
                  sent++;
               end
            end
         end
      end

      // Let the last words drain, then watch a little longer for strays.
      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
`default_nettype wire
